// ===== design/tsr_pkg.sv =====
// Shared constants and types of the timestamped reply framer.
package tsr_pkg;

  // Item operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Default configuration
  localparam int unsigned MAX_PAYLOAD_DEF = 245;
  localparam int unsigned FIFO_DEPTH_DEF  = 4;

  // Frame constants
  localparam logic [7:0]  LEN_EXTRA = 8'd10;
  localparam logic [7:0]  PORT_BYTE = 8'hFF;
  localparam logic [7:0]  TS_FLAG   = 8'h10;
  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam int unsigned SUB_SHIFT = 5;

  // Time split: one million is 64 * 15625, the odd factor is divided in
  // 16-bit digits by a reciprocal multiply, exact for partials below 2^30
  localparam logic [13:0] DIV_DIVISOR     = 14'd15625;
  localparam logic [30:0] DIV_RECIP       = 31'd1125899907;  // ceil(2^44 / 15625)
  localparam int unsigned DIV_RECIP_SHIFT = 44;
  localparam int unsigned DIV_STEPS       = 8;               // 4 digits, each a multiply step and a remainder step
  localparam int unsigned DIV_CNT_W       = $clog2(DIV_STEPS + 1);

  // Classified item handed from the front to the back
  typedef struct packed {
    logic        op;
    logic [7:0]  msg_type;
    logic [7:0]  reg_address;
    logic [7:0]  kind;        // payload kind with timestamp flag
    logic [7:0]  len;         // length byte, count + 10
    logic [63:0] time_us;
    logic [7:0]  data;
    logic        closes;      // checksum follows this item
  } item_t;

  // Divider status and result
  typedef struct packed {
    logic        busy;
    logic [31:0] secs;
    logic [19:0] rem;
  } div_rsp_t;

endpackage

// ===== design/tsr_if.sv =====
// Valid/ready channel interfaces for request items and frame bytes.
interface tsr_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  msg_type;
  logic [7:0]  reg_address;
  logic [7:0]  payload_kind;
  logic [7:0]  payload_count;
  logic [63:0] time_us;
  logic [7:0]  data_byte;

  modport source (
    output valid, op, msg_type, reg_address, payload_kind, payload_count, time_us,
           data_byte,
    input  ready
  );
  modport sink (
    input  valid, op, msg_type, reg_address, payload_kind, payload_count, time_us,
           data_byte,
    output ready
  );
endinterface

interface tsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink (input valid, out_byte, frame_end, output ready);
endinterface

// ===== design/tsr_front.sv =====
// Front end: accepts items, tracks the open frame, drops stray payload beats.
module tsr_front #(
  parameter int unsigned MaxPayload = tsr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tsr_in_if.sink          in_i,
  output tsr_pkg::item_t  item_o,
  output logic            push_o,
  input  logic            full_i
);

  logic       open_q, open_d;
  logic [7:0] left_q, left_d;
  logic       accept;
  logic       is_start;
  logic [7:0] cnt_sat;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_start   = (in_i.op == tsr_pkg::OP_START);

  // Saturate the payload length
  assign cnt_sat = (in_i.payload_count > 8'(MaxPayload)) ? 8'(MaxPayload)
                                                         : in_i.payload_count;

  // Forward starts always, payload beats only inside an open frame
  assign push_o = accept && (is_start || open_q);

  always_comb begin
    item_o.op          = in_i.op;
    item_o.msg_type    = in_i.msg_type;
    item_o.reg_address = in_i.reg_address;
    item_o.kind        = in_i.payload_kind | tsr_pkg::TS_FLAG;
    item_o.len         = cnt_sat + tsr_pkg::LEN_EXTRA;
    item_o.time_us     = in_i.time_us;
    item_o.data        = in_i.data_byte;
    item_o.closes      = is_start ? (cnt_sat == 8'd0) : (left_q == 8'd1);
  end

  // Frame tracking
  always_comb begin
    open_d = open_q;
    left_d = left_q;
    if (accept) begin
      if (is_start) begin
        open_d = (cnt_sat != 8'd0);
        left_d = cnt_sat;
      end else if (open_q) begin
        left_d = left_q - 8'd1;
        open_d = (left_q != 8'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 8'd0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule

// ===== design/tsr_fifo.sv =====
// Small flop-based queue between the front and the back.
module tsr_fifo #(
  parameter int unsigned Depth = tsr_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tsr_pkg::item_t  item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output tsr_pkg::item_t  item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tsr_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== design/tsr_div.sv =====
// Multi-cycle divider of the microsecond time by one million.
module tsr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       dividend_i,
  output tsr_pkg::div_rsp_t rsp_o
);

  logic                          busy_q;
  logic [tsr_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [63:0]                   dvd_q;   // time over 64, digits taken from the top
  logic [5:0]                    low_q;   // time bits below the factor 64
  logic [13:0]                   rem_q;
  logic [31:0]                   quo_q;
  logic [29:0]                   part_q;  // partial dividend of the current digit
  logic [15:0]                   qd_q;    // quotient digit
  logic [29:0]                   part;
  logic [60:0]                   prod;
  logic [15:0]                   qd;
  logic [29:0]                   qd_mul;
  logic                          mul_phase;

  // Even count: reciprocal multiply; odd count: remainder of the digit
  assign mul_phase = !cnt_q[0];
  assign part      = {rem_q, dvd_q[63:48]};
  assign prod      = {31'd0, part} * {30'd0, tsr_pkg::DIV_RECIP};
  assign qd        = prod[tsr_pkg::DIV_RECIP_SHIFT +: 16];
  assign qd_mul    = {14'd0, qd_q} * {16'd0, tsr_pkg::DIV_DIVISOR};

  assign rsp_o.busy = busy_q;
  assign rsp_o.secs = quo_q;
  assign rsp_o.rem  = {rem_q, low_q};

  // Radix-2^16 long division, the low 32 quotient bits are kept
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {6'd0, dividend_i[63:6]};
      low_q <= dividend_i[5:0];
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      if (mul_phase) begin
        part_q <= part;
        qd_q   <= qd;
        dvd_q  <= {dvd_q[47:0], 16'd0};
      end else begin
        rem_q <= 14'(part_q - qd_mul);
        quo_q <= {quo_q[15:0], qd_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= tsr_pkg::DIV_CNT_W'(tsr_pkg::DIV_STEPS);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != tsr_pkg::DIV_CNT_W'(1));
    end
  end

endmodule

// ===== design/tsr_back.sv =====
// Back end: serializes each queued item into frame bytes and the checksum.
module tsr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  tsr_pkg::item_t    item_i,
  output logic              pop_o,
  output logic              div_start_o,
  input  tsr_pkg::div_rsp_t div_rsp_i,
  tsr_out_if.source         out_o
);

  // Byte positions within an item
  localparam logic [3:0] IDX_TYPE  = 4'd0;
  localparam logic [3:0] IDX_LEN   = 4'd1;
  localparam logic [3:0] IDX_ADDR  = 4'd2;
  localparam logic [3:0] IDX_PORT  = 4'd3;
  localparam logic [3:0] IDX_KIND  = 4'd4;
  localparam logic [3:0] IDX_SEC0  = 4'd5;
  localparam logic [3:0] IDX_SEC1  = 4'd6;
  localparam logic [3:0] IDX_SEC2  = 4'd7;
  localparam logic [3:0] IDX_SEC3  = 4'd8;
  localparam logic [3:0] IDX_SUB0  = 4'd9;
  localparam logic [3:0] IDX_SUB1  = 4'd10;
  localparam logic [3:0] IDX_CSUM  = 4'd11;
  localparam logic [3:0] IDX_DATA  = 4'd0;
  localparam logic [3:0] IDX_PCSUM = 4'd1;

  tsr_pkg::item_t cur_q;
  logic           cur_valid_q;
  logic [3:0]     idx_q;
  logic [7:0]     sum_q;
  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic           frame_end_q;

  logic           is_start;
  logic           can_emit;
  logic           is_csum;
  logic           last;
  logic           done;
  logic [7:0]     byte_w;
  logic [15:0]    sub_w;

  assign sub_w    = 16'(div_rsp_i.rem >> tsr_pkg::SUB_SHIFT);
  assign is_start = (cur_q.op == tsr_pkg::OP_START);

  // Time bytes wait for the divider
  assign can_emit = cur_valid_q && (!out_valid_q || out_o.ready)
                    && !(is_start && (idx_q >= IDX_SEC0) && div_rsp_i.busy);

  assign is_csum = is_start ? (idx_q == IDX_CSUM) : (idx_q == IDX_PCSUM);
  assign last    = is_start ? ((idx_q == IDX_SUB1) && !cur_q.closes) || (idx_q == IDX_CSUM)
                            : ((idx_q == IDX_DATA) && !cur_q.closes) || (idx_q == IDX_PCSUM);
  assign done    = can_emit && last;

  assign pop_o       = !empty_i && (!cur_valid_q || done);
  assign div_start_o = pop_o && (item_i.op == tsr_pkg::OP_START);

  // Byte select
  always_comb begin
    byte_w = sum_q;
    if (is_start) begin
      unique case (idx_q)
        IDX_TYPE: byte_w = cur_q.msg_type;
        IDX_LEN:  byte_w = cur_q.len;
        IDX_ADDR: byte_w = cur_q.reg_address;
        IDX_PORT: byte_w = tsr_pkg::PORT_BYTE;
        IDX_KIND: byte_w = cur_q.kind;
        IDX_SEC0: byte_w = div_rsp_i.secs[7:0];
        IDX_SEC1: byte_w = div_rsp_i.secs[15:8];
        IDX_SEC2: byte_w = div_rsp_i.secs[23:16];
        IDX_SEC3: byte_w = div_rsp_i.secs[31:24];
        IDX_SUB0: byte_w = sub_w[7:0];
        IDX_SUB1: byte_w = sub_w[15:8];
        default:  byte_w = sum_q;
      endcase
    end else if (idx_q == IDX_DATA) begin
      byte_w = cur_q.data;
    end
  end

  // Current item
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      sum_q       <= 8'd0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (done) begin
        cur_valid_q <= 1'b0;
      end else if (can_emit) begin
        idx_q <= idx_q + 4'd1;
      end
      // Running checksum, restarted on the first header byte
      if (can_emit) begin
        if (is_csum) begin
          sum_q <= 8'd0;
        end else if (is_start && (idx_q == IDX_TYPE)) begin
          sum_q <= byte_w;
        end else begin
          sum_q <= sum_q + byte_w;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_emit) begin
      out_byte_q  <= byte_w;
      frame_end_q <= is_csum;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.frame_end = frame_end_q;

endmodule

// ===== design/timestamped_reply_framer.sv =====
// Timestamped reply framer: turns reply requests into a framed byte stream.
//
// Channels: in_i carries request items (op 0 opens a frame with header
// fields and a 64-bit microsecond time, op 1 carries one payload byte);
// out_o carries one frame byte per beat, frame_end marking the checksum.
// A start item yields type, length, address, port, kind, four bytes of
// seconds, two bytes of sub-second and, for an empty frame, the checksum.
// Payload beats outside an open frame are dropped at the front.
// A payload beat passes the queue, the current-item register and the output
// register on its way to out_o. Throughput: one payload byte per cycle while
// the queue holds items and the receiver is ready. The time bytes of a start
// item wait for the divider that splits the time into seconds in four 16-bit
// digits; the five header bytes leave while it runs.
// The front keeps accepting into a FifoDepth queue while the back works.
// When the receiver stalls, the output register holds its beat, the back
// stops, the queue fills and in_i.ready drops when it is full.
// Reset clears the frame state, the queue, the checksum and the output.
module timestamped_reply_framer #(
  parameter int unsigned MaxPayload = tsr_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned FifoDepth  = tsr_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsr_in_if.sink     in_i,
  tsr_out_if.source  out_o
);

  tsr_pkg::item_t    push_item;
  tsr_pkg::item_t    head_item;
  tsr_pkg::div_rsp_t div_rsp;
  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  logic              div_start;

  // Classification
  tsr_front #(.MaxPayload(MaxPayload)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .item_o (push_item),
    .push_o (push),
    .full_i (full)
  );

  // Decoupling queue
  tsr_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (head_item)
  );

  // Time split
  tsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (head_item.time_us),
    .rsp_o      (div_rsp)
  );

  // Serializer
  tsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .div_start_o (div_start),
    .div_rsp_i   (div_rsp),
    .out_o       (out_o)
  );

  // A new division only starts once the previous frame has used its result
  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_rsp.busy)
    else $error("divider did not start");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule
